// ===== sv/msepc_pkg.sv =====
// ----------------------------------------------------------------------------
// msepc_pkg: shared types and codes for the short MIDI event packet codec
// Holds the code index numbers, the status bytes the codec knows and the
// request/response payload structs.
// ----------------------------------------------------------------------------
package msepc_pkg;

   // direction select
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // code index numbers
   localparam logic [3:0] CIN_SYS_2BYTE   = 4'h2;
   localparam logic [3:0] CIN_SYS_3BYTE   = 4'h3;
   localparam logic [3:0] CIN_SYS_1BYTE   = 4'h5;
   localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
   localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
   localparam logic [3:0] CIN_POLY_PRESS  = 4'hA;
   localparam logic [3:0] CIN_CTRL_CHANGE = 4'hB;
   localparam logic [3:0] CIN_PROG_CHANGE = 4'hC;
   localparam logic [3:0] CIN_CHAN_PRESS  = 4'hD;
   localparam logic [3:0] CIN_PITCH_BEND  = 4'hE;
   localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

   // status bytes
   localparam logic [7:0] ST_CHAN_FIRST   = 8'h80;
   localparam logic [7:0] ST_CHAN_LAST    = 8'hEF;
   localparam logic [7:0] ST_TIME_CODE    = 8'hF1;
   localparam logic [7:0] ST_SONG_POS     = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
   localparam logic [7:0] ST_TUNE_REQ     = 8'hF6;
   localparam logic [7:0] ST_CLOCK        = 8'hF8;
   localparam logic [7:0] ST_START        = 8'hFA;
   localparam logic [7:0] ST_CONTINUE     = 8'hFB;
   localparam logic [7:0] ST_STOP         = 8'hFC;
   localparam logic [7:0] ST_ACT_SENSE    = 8'hFE;
   localparam logic [7:0] ST_RESET        = 8'hFF;

   // message lengths
   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef struct packed {
      logic       op;
      logic [7:0] cable;
      logic [7:0] status;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [7:0] pkt_header;
      logic [7:0] pkt_byte0;
      logic [7:0] pkt_byte1;
      logic [7:0] pkt_byte2;
   } msepc_req_type;

   typedef struct packed {
      logic       error;
      logic [7:0] out_header;
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [3:0] msg_cable;
      logic [7:0] msg_status;
      logic [6:0] msg_data1;
      logic [6:0] msg_data2;
      logic [1:0] msg_length;
   } msepc_rsp_type;

endpackage

// ===== sv/midi_short_event_packet_codec_top.sv =====
// ----------------------------------------------------------------------------
// midi_short_event_packet_codec_top: short MIDI message <-> USB-MIDI packet
// Two-register pipeline around the combinational codec.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. A new transfer is taken every
// cycle: the input register feeds the codec logic, whose answer lands in
// the output register, and the input side stalls only when both registers
// are full and the output is stalled. req_op selects encode (0) or decode
// (1); invalid input returns rsp_error with every other field zero. SysEx
// is not supported.
module midi_short_event_packet_codec_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_cable,
   input  logic [7:0] req_status,
   input  logic [7:0] req_data1,
   input  logic [7:0] req_data2,
   input  logic [7:0] req_pkt_header,
   input  logic [7:0] req_pkt_byte0,
   input  logic [7:0] req_pkt_byte1,
   input  logic [7:0] req_pkt_byte2,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_error,
   output logic [7:0] rsp_out_header,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [3:0] rsp_msg_cable,
   output logic [7:0] rsp_msg_status,
   output logic [6:0] rsp_msg_data1,
   output logic [6:0] rsp_msg_data2,
   output logic [1:0] rsp_msg_length
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   msepc_pkg::msepc_req_type in_data_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   msepc_pkg::msepc_rsp_type out_data_ff;
   msepc_pkg::msepc_rsp_type codec_rsp;
   logic                     out_load;
   logic                     in_load;

   // pipeline advance control
   assign out_load    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_load     = req_valid && !req_stall;
   assign req_stall   = in_valid_ff && !out_load;
   assign in_valid_in = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= '{op: req_op, cable: req_cable, status: req_status,
                         data1: req_data1, data2: req_data2,
                         pkt_header: req_pkt_header, pkt_byte0: req_pkt_byte0,
                         pkt_byte1: req_pkt_byte1, pkt_byte2: req_pkt_byte2};
      end
   end

   msepc_codec u_codec (
      .req (in_data_ff),
      .rsp (codec_rsp)
   );

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= codec_rsp;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_error      = out_data_ff.error;
   assign rsp_out_header = out_data_ff.out_header;
   assign rsp_out_byte0  = out_data_ff.out_byte0;
   assign rsp_out_byte1  = out_data_ff.out_byte1;
   assign rsp_out_byte2  = out_data_ff.out_byte2;
   assign rsp_msg_cable  = out_data_ff.msg_cable;
   assign rsp_msg_status = out_data_ff.msg_status;
   assign rsp_msg_data1  = out_data_ff.msg_data1;
   assign rsp_msg_data2  = out_data_ff.msg_data2;
   assign rsp_msg_length = out_data_ff.msg_length;

endmodule

// ===== sv/msepc_codec.sv =====
// ----------------------------------------------------------------------------
// msepc_codec: combinational encode/decode of one MIDI message or packet
// Validates the item, builds either the packet or the message fields, and
// forces every field to zero with the error flag on invalid input.
// ----------------------------------------------------------------------------
module msepc_codec (
   input  msepc_pkg::msepc_req_type req,
   output msepc_pkg::msepc_rsp_type rsp
);

   // encode path
   logic       enc_err;
   logic [3:0] enc_cin;
   logic [7:0] enc_d1;
   logic [7:0] enc_d2;

   always_comb begin
      enc_err = (req.cable[7:4] != 4'h0);
      enc_cin = req.status[7:4];
      enc_d1  = req.data1;
      enc_d2  = req.data2;
      case (req.status) inside
         [msepc_pkg::ST_CHAN_FIRST:msepc_pkg::ST_CHAN_LAST]: begin
            enc_cin = req.status[7:4];
            if (req.data1[7]) enc_err = 1'b1;
            // program change and channel pressure carry one data byte
            if (enc_cin == msepc_pkg::CIN_PROG_CHANGE ||
                enc_cin == msepc_pkg::CIN_CHAN_PRESS) begin
               enc_d2 = 8'h00;
            end else if (req.data2[7]) begin
               enc_err = 1'b1;
            end
         end
         msepc_pkg::ST_TIME_CODE, msepc_pkg::ST_SONG_SEL: begin
            if (req.data1[7]) enc_err = 1'b1;
            enc_cin = msepc_pkg::CIN_SYS_2BYTE;
            enc_d2  = 8'h00;
         end
         msepc_pkg::ST_SONG_POS: begin
            if (req.data1[7] || req.data2[7]) enc_err = 1'b1;
            enc_cin = msepc_pkg::CIN_SYS_3BYTE;
         end
         msepc_pkg::ST_TUNE_REQ: begin
            enc_cin = msepc_pkg::CIN_SYS_1BYTE;
            enc_d1  = 8'h00;
            enc_d2  = 8'h00;
         end
         msepc_pkg::ST_CLOCK, msepc_pkg::ST_START, msepc_pkg::ST_CONTINUE,
         msepc_pkg::ST_STOP, msepc_pkg::ST_ACT_SENSE, msepc_pkg::ST_RESET: begin
            enc_cin = msepc_pkg::CIN_SINGLE_BYTE;
            enc_d1  = 8'h00;
            enc_d2  = 8'h00;
         end
         default: begin
            enc_err = 1'b1;
         end
      endcase
   end

   // decode path
   logic       dec_err;
   logic [3:0] dec_cin;
   logic [1:0] dec_len;
   logic       nib_match;

   assign dec_cin   = req.pkt_header[3:0];
   assign nib_match = (req.pkt_byte0[7:4] == dec_cin);

   always_comb begin
      dec_err = 1'b0;
      dec_len = msepc_pkg::LEN_THREE;
      case (dec_cin) inside
         msepc_pkg::CIN_NOTE_OFF, msepc_pkg::CIN_NOTE_ON, msepc_pkg::CIN_POLY_PRESS,
         msepc_pkg::CIN_CTRL_CHANGE, msepc_pkg::CIN_PITCH_BEND: begin
            dec_err = !nib_match || req.pkt_byte1[7] || req.pkt_byte2[7];
            dec_len = msepc_pkg::LEN_THREE;
         end
         msepc_pkg::CIN_PROG_CHANGE, msepc_pkg::CIN_CHAN_PRESS: begin
            dec_err = !nib_match || req.pkt_byte1[7] || (req.pkt_byte2 != 8'h00);
            dec_len = msepc_pkg::LEN_TWO;
         end
         msepc_pkg::CIN_SYS_2BYTE: begin
            dec_err = !(req.pkt_byte0 inside {msepc_pkg::ST_TIME_CODE,
                                              msepc_pkg::ST_SONG_SEL}) ||
                      req.pkt_byte1[7] || (req.pkt_byte2 != 8'h00);
            dec_len = msepc_pkg::LEN_TWO;
         end
         msepc_pkg::CIN_SYS_3BYTE: begin
            dec_err = (req.pkt_byte0 != msepc_pkg::ST_SONG_POS) ||
                      req.pkt_byte1[7] || req.pkt_byte2[7];
            dec_len = msepc_pkg::LEN_THREE;
         end
         msepc_pkg::CIN_SYS_1BYTE: begin
            dec_err = (req.pkt_byte0 != msepc_pkg::ST_TUNE_REQ) ||
                      (req.pkt_byte1 != 8'h00) || (req.pkt_byte2 != 8'h00);
            dec_len = msepc_pkg::LEN_ONE;
         end
         msepc_pkg::CIN_SINGLE_BYTE: begin
            dec_err = !(req.pkt_byte0 inside {msepc_pkg::ST_CLOCK, msepc_pkg::ST_START,
                                              msepc_pkg::ST_CONTINUE, msepc_pkg::ST_STOP,
                                              msepc_pkg::ST_ACT_SENSE,
                                              msepc_pkg::ST_RESET}) ||
                      (req.pkt_byte1 != 8'h00) || (req.pkt_byte2 != 8'h00);
            dec_len = msepc_pkg::LEN_ONE;
         end
         default: begin
            dec_err = 1'b1;
         end
      endcase
   end

   // result select; other direction's fields stay zero
   always_comb begin
      rsp = '0;
      if (req.op == msepc_pkg::OP_ENCODE) begin
         if (enc_err) begin
            rsp.error = 1'b1;
         end else begin
            rsp.out_header = {req.cable[3:0], enc_cin};
            rsp.out_byte0  = req.status;
            rsp.out_byte1  = enc_d1;
            rsp.out_byte2  = enc_d2;
         end
      end else begin
         if (dec_err) begin
            rsp.error = 1'b1;
         end else begin
            rsp.msg_cable  = req.pkt_header[7:4];
            rsp.msg_status = req.pkt_byte0;
            rsp.msg_data1  = req.pkt_byte1[6:0];
            rsp.msg_data2  = req.pkt_byte2[6:0];
            rsp.msg_length = dec_len;
         end
      end
   end

endmodule

// ===== sv/msepc_checker.sv =====
// ----------------------------------------------------------------------------
// msepc_checker: port-level checks for the MIDI packet codec
// Watches the response channel for field consistency and handshake holding.
// ----------------------------------------------------------------------------
module msepc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_error,
   input logic [7:0] rsp_out_header,
   input logic [7:0] rsp_out_byte0,
   input logic [7:0] rsp_out_byte1,
   input logic [7:0] rsp_out_byte2,
   input logic [3:0] rsp_msg_cable,
   input logic [7:0] rsp_msg_status,
   input logic [6:0] rsp_msg_data1,
   input logic [6:0] rsp_msg_data2,
   input logic [1:0] rsp_msg_length
);

   // an error transfer carries nothing else
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_header == 8'h00 && rsp_out_byte0 == 8'h00 &&
      rsp_out_byte1 == 8'h00 && rsp_out_byte2 == 8'h00 && rsp_msg_cable == 4'h0 &&
      rsp_msg_status == 8'h00 && rsp_msg_data1 == 7'h00 && rsp_msg_data2 == 7'h00 &&
      rsp_msg_length == 2'd0)
      else $error("error transfer with nonzero fields");

   // a decoded message leaves the packet fields clear and has a status byte
   a_decode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error && rsp_msg_length != 2'd0 |->
      rsp_out_header == 8'h00 && rsp_out_byte0 == 8'h00 && rsp_msg_status[7])
      else $error("decode transfer with packet fields set");

   // an encoded packet carries a status byte and clear message fields
   a_encode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error && rsp_msg_length == 2'd0 |->
      rsp_out_byte0[7] && rsp_msg_status == 8'h00 && rsp_msg_cable == 4'h0)
      else $error("encode transfer malformed");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_error) &&
      $stable(rsp_out_header) && $stable(rsp_msg_status) && $stable(rsp_msg_length))
      else $error("stalled response changed");

   // an accepted request shows up on the response side, past the input and output registers
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("accepted request produced no response");

endmodule

bind midi_short_event_packet_codec_top msepc_checker u_msepc_checker (.*);

// ===== dv/midi_short_event_packet_codec_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_short_event_packet_codec_top_tb: testbench for the MIDI packet codec
// Sends encode and decode requests, directed first and then random, through
// the valid/stall request channel. Every transfer is scored against an
// in-bench model of the codec. Both the sender and the receiver idle at
// random, and one long receiver hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
module midi_short_event_packet_codec_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 1500;
   localparam int BACKED_ITEMS = 250;

   localparam logic [7:0] DATA_MAX  = 8'h7F;
   localparam logic [7:0] CABLE_MAX = 8'h0F;

   // code index numbers the codec refuses
   localparam logic [3:0] CIN_MISC        = 4'h0;
   localparam logic [3:0] CIN_CABLE_EVENT = 4'h1;
   localparam logic [3:0] CIN_SYSEX_START = 4'h4;
   localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
   localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;

   // system status bytes the codec refuses (sysex, undefined, end of sysex)
   localparam logic [5:0][7:0] UNDEF_SYS_BYTES =
      {8'hF0, 8'hF4, 8'hF5, 8'hF7, 8'hF9, 8'hFD};
   localparam logic [9:0][7:0] SYS_BYTES =
      {msepc_pkg::ST_TIME_CODE, msepc_pkg::ST_SONG_POS, msepc_pkg::ST_SONG_SEL,
       msepc_pkg::ST_TUNE_REQ, msepc_pkg::ST_CLOCK, msepc_pkg::ST_START,
       msepc_pkg::ST_CONTINUE, msepc_pkg::ST_STOP, msepc_pkg::ST_ACT_SENSE,
       msepc_pkg::ST_RESET};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = msepc_pkg::OP_ENCODE;
   logic [7:0] req_cable = '0;
   logic [7:0] req_status = '0;
   logic [7:0] req_data1 = '0;
   logic [7:0] req_data2 = '0;
   logic [7:0] req_pkt_header = '0;
   logic [7:0] req_pkt_byte0 = '0;
   logic [7:0] req_pkt_byte1 = '0;
   logic [7:0] req_pkt_byte2 = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_error;
   logic [7:0] rsp_out_header;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [3:0] rsp_msg_cable;
   logic [7:0] rsp_msg_status;
   logic [6:0] rsp_msg_data1;
   logic [6:0] rsp_msg_data2;
   logic [1:0] rsp_msg_length;

   msepc_pkg::msepc_rsp_type expected_rsp_q[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            burst_left = 0;
   bit            no_gaps = 1'b0;
   bit            hold_request = 1'b0;
   int            hold_left = 0;
   int            seg_left = 0;
   int            seg_mode = 0;

   midi_short_event_packet_codec_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_cable      (req_cable),
      .req_status     (req_status),
      .req_data1      (req_data1),
      .req_data2      (req_data2),
      .req_pkt_header (req_pkt_header),
      .req_pkt_byte0  (req_pkt_byte0),
      .req_pkt_byte1  (req_pkt_byte1),
      .req_pkt_byte2  (req_pkt_byte2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_error      (rsp_error),
      .rsp_out_header (rsp_out_header),
      .rsp_out_byte0  (rsp_out_byte0),
      .rsp_out_byte1  (rsp_out_byte1),
      .rsp_out_byte2  (rsp_out_byte2),
      .rsp_msg_cable  (rsp_msg_cable),
      .rsp_msg_status (rsp_msg_status),
      .rsp_msg_data1  (rsp_msg_data1),
      .rsp_msg_data2  (rsp_msg_data2),
      .rsp_msg_length (rsp_msg_length)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic bit is_realtime(input logic [7:0] st);
      return st == msepc_pkg::ST_CLOCK || st == msepc_pkg::ST_START ||
             st == msepc_pkg::ST_CONTINUE || st == msepc_pkg::ST_STOP ||
             st == msepc_pkg::ST_ACT_SENSE || st == msepc_pkg::ST_RESET;
   endfunction

   // expected codec answer for one request
   function automatic msepc_pkg::msepc_rsp_type codec_answer(
      input msepc_pkg::msepc_req_type r);
      msepc_pkg::msepc_rsp_type p;
      bit            ok;
      logic [3:0]    cin;
      logic [7:0]    d1;
      logic [7:0]    d2;
      logic [1:0]    len;
      p   = '0;
      ok  = 1'b1;
      cin = r.pkt_header[3:0];
      len = '0;
      if (r.op == msepc_pkg::OP_ENCODE) begin
         d1 = r.data1;
         d2 = r.data2;
         if (r.cable > CABLE_MAX) begin
            ok = 1'b0;
         end else if (r.status >= msepc_pkg::ST_CHAN_FIRST &&
                      r.status <= msepc_pkg::ST_CHAN_LAST) begin
            cin = r.status[7:4];
            if (d1 > DATA_MAX) ok = 1'b0;
            if (cin == msepc_pkg::CIN_PROG_CHANGE || cin == msepc_pkg::CIN_CHAN_PRESS)
               d2 = '0;
            else if (d2 > DATA_MAX) ok = 1'b0;
         end else if (r.status == msepc_pkg::ST_TIME_CODE ||
                      r.status == msepc_pkg::ST_SONG_SEL) begin
            if (d1 > DATA_MAX) ok = 1'b0;
            cin = msepc_pkg::CIN_SYS_2BYTE;
            d2  = '0;
         end else if (r.status == msepc_pkg::ST_SONG_POS) begin
            if (d1 > DATA_MAX || d2 > DATA_MAX) ok = 1'b0;
            cin = msepc_pkg::CIN_SYS_3BYTE;
         end else if (r.status == msepc_pkg::ST_TUNE_REQ) begin
            cin = msepc_pkg::CIN_SYS_1BYTE;
            d1  = '0;
            d2  = '0;
         end else if (is_realtime(r.status)) begin
            cin = msepc_pkg::CIN_SINGLE_BYTE;
            d1  = '0;
            d2  = '0;
         end else begin
            ok = 1'b0;
         end
         if (ok) begin
            p.out_header = {r.cable[3:0], cin};
            p.out_byte0  = r.status;
            p.out_byte1  = d1;
            p.out_byte2  = d2;
         end
      end else begin
         d1 = r.pkt_byte1;
         d2 = r.pkt_byte2;
         case (cin)
            msepc_pkg::CIN_NOTE_OFF, msepc_pkg::CIN_NOTE_ON, msepc_pkg::CIN_POLY_PRESS,
            msepc_pkg::CIN_CTRL_CHANGE, msepc_pkg::CIN_PITCH_BEND: begin
               ok  = r.pkt_byte0[7:4] == cin && d1 <= DATA_MAX && d2 <= DATA_MAX;
               len = msepc_pkg::LEN_THREE;
            end
            msepc_pkg::CIN_PROG_CHANGE, msepc_pkg::CIN_CHAN_PRESS: begin
               ok  = r.pkt_byte0[7:4] == cin && d1 <= DATA_MAX && d2 == '0;
               len = msepc_pkg::LEN_TWO;
            end
            msepc_pkg::CIN_SYS_2BYTE: begin
               ok  = (r.pkt_byte0 == msepc_pkg::ST_TIME_CODE ||
                      r.pkt_byte0 == msepc_pkg::ST_SONG_SEL) &&
                     d1 <= DATA_MAX && d2 == '0;
               len = msepc_pkg::LEN_TWO;
            end
            msepc_pkg::CIN_SYS_3BYTE: begin
               ok  = r.pkt_byte0 == msepc_pkg::ST_SONG_POS && d1 <= DATA_MAX &&
                     d2 <= DATA_MAX;
               len = msepc_pkg::LEN_THREE;
            end
            msepc_pkg::CIN_SYS_1BYTE: begin
               ok  = r.pkt_byte0 == msepc_pkg::ST_TUNE_REQ && d1 == '0 && d2 == '0;
               len = msepc_pkg::LEN_ONE;
            end
            msepc_pkg::CIN_SINGLE_BYTE: begin
               ok  = is_realtime(r.pkt_byte0) && d1 == '0 && d2 == '0;
               len = msepc_pkg::LEN_ONE;
            end
            default: ok = 1'b0;
         endcase
         if (ok) begin
            p.msg_cable  = r.pkt_header[7:4];
            p.msg_status = r.pkt_byte0;
            p.msg_data1  = d1[6:0];
            p.msg_data2  = d2[6:0];
            p.msg_length = len;
         end
      end
      if (!ok) begin
         p       = '0;
         p.error = 1'b1;
      end
      return p;
   endfunction

   // every field random; the base for all requests
   function automatic msepc_pkg::msepc_req_type rand_req();
      msepc_pkg::msepc_req_type r;
      r.op         = 1'($urandom);
      r.cable      = 8'($urandom);
      r.status     = 8'($urandom);
      r.data1      = 8'($urandom);
      r.data2      = 8'($urandom);
      r.pkt_header = 8'($urandom);
      r.pkt_byte0  = 8'($urandom);
      r.pkt_byte1  = 8'($urandom);
      r.pkt_byte2  = 8'($urandom);
      return r;
   endfunction

   // encode request; decode fields carry noise the codec must ignore
   function automatic msepc_pkg::msepc_req_type enc_req(input logic [7:0] cable, st, d1,
                                                        d2);
      msepc_pkg::msepc_req_type r;
      r        = rand_req();
      r.op     = msepc_pkg::OP_ENCODE;
      r.cable  = cable;
      r.status = st;
      r.data1  = d1;
      r.data2  = d2;
      return r;
   endfunction

   // decode request; encode fields carry noise the codec must ignore
   function automatic msepc_pkg::msepc_req_type dec_req(input logic [7:0] hdr, b0, b1,
                                                        b2);
      msepc_pkg::msepc_req_type r;
      r            = rand_req();
      r.op         = msepc_pkg::OP_DECODE;
      r.pkt_header = hdr;
      r.pkt_byte0  = b0;
      r.pkt_byte1  = b1;
      r.pkt_byte2  = b2;
      return r;
   endfunction

   // legal encode request with random content
   function automatic msepc_pkg::msepc_req_type legal_message();
      logic [7:0] st;
      logic [7:0] d1;
      logic [7:0] d2;
      if ($urandom_range(0, 99) < 70)
         st = 8'($urandom_range(msepc_pkg::ST_CHAN_FIRST, msepc_pkg::ST_CHAN_LAST));
      else st = SYS_BYTES[$urandom_range(0, 9)];
      d1 = 8'($urandom_range(0, DATA_MAX));
      d2 = 8'($urandom_range(0, DATA_MAX));
      // bytes the codec forces to zero may hold anything
      if ($urandom_range(0, 1)) begin
         if (st[7:4] == msepc_pkg::CIN_PROG_CHANGE || st[7:4] == msepc_pkg::CIN_CHAN_PRESS ||
             st == msepc_pkg::ST_TIME_CODE || st == msepc_pkg::ST_SONG_SEL) begin
            d2 = 8'($urandom);
         end else if (st == msepc_pkg::ST_TUNE_REQ || is_realtime(st)) begin
            d1 = 8'($urandom);
            d2 = 8'($urandom);
         end
      end
      return enc_req(8'($urandom_range(0, CABLE_MAX)), st, d1, d2);
   endfunction

   // one request transfer, with the sender's burst/gap pattern in front
   task automatic send_item(input msepc_pkg::msepc_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_op         <= r.op;
      req_cable      <= r.cable;
      req_status     <= r.status;
      req_data1      <= r.data1;
      req_data2      <= r.data2;
      req_pkt_header <= r.pkt_header;
      req_pkt_byte0  <= r.pkt_byte0;
      req_pkt_byte1  <= r.pkt_byte1;
      req_pkt_byte2  <= r.pkt_byte2;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.push_back(codec_answer(r));
      burst_left--;
   endtask

   // receiver stall pattern: random segments, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD - 1;
         rsp_stall   <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(1, 64);
            seg_mode = $urandom_range(0, 3);
         end
         seg_left--;
         case (seg_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 3) == 0;
            2:       rsp_stall <= $urandom_range(0, 1) == 0;
            default: rsp_stall <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // score each response transfer against the oldest expectation
   always @(posedge clock) begin : rsp_check
      msepc_pkg::msepc_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: response expected none actual error=%b header=%h status=%h",
                     $time, rsp_error, rsp_out_header, rsp_msg_status);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            check_field("error",      8'(exp_rsp.error),      8'(rsp_error));
            check_field("out_header", exp_rsp.out_header,     rsp_out_header);
            check_field("out_byte0",  exp_rsp.out_byte0,      rsp_out_byte0);
            check_field("out_byte1",  exp_rsp.out_byte1,      rsp_out_byte1);
            check_field("out_byte2",  exp_rsp.out_byte2,      rsp_out_byte2);
            check_field("msg_cable",  8'(exp_rsp.msg_cable),  8'(rsp_msg_cable));
            check_field("msg_status", exp_rsp.msg_status,     rsp_msg_status);
            check_field("msg_data1",  8'(exp_rsp.msg_data1),  8'(rsp_msg_data1));
            check_field("msg_data2",  8'(exp_rsp.msg_data2),  8'(rsp_msg_data2));
            check_field("msg_length", 8'(exp_rsp.msg_length), 8'(rsp_msg_length));
         end
      end
   end

   // encode: each message class but poly pressure, field extremes and each refusal
   task automatic test_encode_directed();
      int i;
      send_item(enc_req(8'h00, msepc_pkg::ST_CHAN_FIRST, 8'h00, 8'h00));
      send_item(enc_req(CABLE_MAX, {msepc_pkg::CIN_NOTE_ON, 4'hF}, DATA_MAX, DATA_MAX));
      send_item(enc_req(8'h02, {msepc_pkg::CIN_CTRL_CHANGE, 4'hA}, 8'h12, 8'h34));
      // program change and channel pressure drop the second data byte
      send_item(enc_req(CABLE_MAX, {msepc_pkg::CIN_PROG_CHANGE, 4'hF}, DATA_MAX, 8'hFF));
      send_item(enc_req(8'h01, {msepc_pkg::CIN_CHAN_PRESS, 4'h3}, 8'h55, 8'h80));
      send_item(enc_req(8'h04, msepc_pkg::ST_CHAN_LAST, 8'h00, DATA_MAX));
      // cable out of range, data bytes as status, data above 0x7F
      send_item(enc_req(8'h10, {msepc_pkg::CIN_NOTE_ON, 4'h0}, 8'h01, 8'h01));
      send_item(enc_req(8'hFF, {msepc_pkg::CIN_POLY_PRESS, 4'h0}, 8'h01, 8'h01));
      send_item(enc_req(8'h00, 8'h7F, 8'h01, 8'h01));
      send_item(enc_req(8'h00, {msepc_pkg::CIN_NOTE_ON, 4'h0}, 8'h80, 8'h00));
      send_item(enc_req(8'h00, {msepc_pkg::CIN_PITCH_BEND, 4'h0}, 8'h00, 8'h80));
      // system common and realtime
      send_item(enc_req(8'h05, msepc_pkg::ST_TIME_CODE, DATA_MAX, 8'hFF));
      send_item(enc_req(8'h06, msepc_pkg::ST_SONG_POS, DATA_MAX, DATA_MAX));
      send_item(enc_req(8'h07, msepc_pkg::ST_TUNE_REQ, 8'hFF, 8'hFF));
      send_item(enc_req(8'h08, msepc_pkg::ST_RESET, 8'hFF, 8'hFF));
      for (i = 0; i < 6; i++) send_item(enc_req(8'h09, UNDEF_SYS_BYTES[i], 8'h00, 8'h00));
   endtask

   // decode: code indexes 8, 9, C, 2, 3, 5, F and E, mismatches and refused code indexes
   task automatic test_decode_directed();
      send_item(dec_req({4'h0, msepc_pkg::CIN_NOTE_OFF}, msepc_pkg::ST_CHAN_FIRST,
                        8'h00, 8'h00));
      send_item(dec_req({4'hF, msepc_pkg::CIN_NOTE_ON}, {msepc_pkg::CIN_NOTE_ON, 4'hF},
                        DATA_MAX, DATA_MAX));
      send_item(dec_req({4'h3, msepc_pkg::CIN_PROG_CHANGE},
                        {msepc_pkg::CIN_PROG_CHANGE, 4'h5}, DATA_MAX, 8'h00));
      send_item(dec_req({4'h3, msepc_pkg::CIN_PROG_CHANGE},
                        {msepc_pkg::CIN_PROG_CHANGE, 4'h5}, DATA_MAX, 8'h01));
      send_item(dec_req({4'h4, msepc_pkg::CIN_SYS_2BYTE}, msepc_pkg::ST_SONG_SEL,
                        DATA_MAX, 8'h00));
      send_item(dec_req({4'h5, msepc_pkg::CIN_SYS_3BYTE}, msepc_pkg::ST_SONG_POS,
                        DATA_MAX, DATA_MAX));
      send_item(dec_req({4'h6, msepc_pkg::CIN_SYS_1BYTE}, msepc_pkg::ST_TUNE_REQ,
                        8'h00, 8'h00));
      send_item(dec_req({4'h7, msepc_pkg::CIN_SINGLE_BYTE}, msepc_pkg::ST_CLOCK,
                        8'h00, 8'h00));
      send_item(dec_req({4'h7, msepc_pkg::CIN_SINGLE_BYTE}, msepc_pkg::ST_CLOCK,
                        8'h01, 8'h00));
      send_item(dec_req({4'h9, msepc_pkg::CIN_NOTE_ON}, {msepc_pkg::CIN_NOTE_OFF, 4'h9},
                        8'h10, 8'h10));
      send_item(dec_req({4'hA, msepc_pkg::CIN_PITCH_BEND}, msepc_pkg::ST_CHAN_LAST,
                        8'h80, 8'h00));
      send_item(dec_req({4'h1, CIN_MISC}, msepc_pkg::ST_CHAN_FIRST, 8'h00, 8'h00));
      send_item(dec_req({4'h2, CIN_CABLE_EVENT}, msepc_pkg::ST_CHAN_FIRST, 8'h00, 8'h00));
      send_item(dec_req({4'h3, CIN_SYSEX_START}, 8'hF0, 8'h01, 8'h02));
      send_item(dec_req({4'h4, CIN_SYSEX_END2}, 8'h01, 8'hF7, 8'h00));
      send_item(dec_req({4'h5, CIN_SYSEX_END3}, 8'h01, 8'h02, 8'hF7));
   endtask

   // mostly well-formed messages and packets, some with one bit flipped,
   // the rest pure noise
   task automatic test_random_traffic(input int count);
      int                       i;
      int                       kind;
      int                       bit_pos;
      logic [31:0]              flip;
      msepc_pkg::msepc_req_type r;
      msepc_pkg::msepc_rsp_type pkt;
      for (i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         r    = legal_message();
         if (kind >= 40 && kind < 88 && $urandom_range(0, 2) != 0) begin
            pkt = codec_answer(r);
            r   = dec_req(pkt.out_header, pkt.out_byte0, pkt.out_byte1, pkt.out_byte2);
         end
         if (kind >= 75 && kind < 88) begin
            bit_pos = $urandom_range(0, 31);
            flip    = 32'(1) << bit_pos;
            if (r.op == msepc_pkg::OP_ENCODE)
               {r.cable, r.status, r.data1, r.data2} =
                  {r.cable, r.status, r.data1, r.data2} ^ flip;
            else
               {r.pkt_header, r.pkt_byte0, r.pkt_byte1, r.pkt_byte2} =
                  {r.pkt_header, r.pkt_byte0, r.pkt_byte1, r.pkt_byte2} ^ flip;
         end else if (kind >= 88) begin
            r = rand_req();
         end
         send_item(r);
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure(input int count);
      hold_request = 1'b1;
      no_gaps      = 1'b1;
      test_random_traffic(40);
      no_gaps      = 1'b0;
      test_random_traffic(count - 40);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_encode_directed();
      test_decode_directed();
      test_random_traffic(RANDOM_ITEMS);
      test_backpressure(BACKED_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
